// File: design/aging_page_replacement_assert.svh
// Assertion macros shared by the aging page replacement modules.
`ifndef AGING_PAGE_REPLACEMENT_ASSERT_SVH
`define AGING_PAGE_REPLACEMENT_ASSERT_SVH
`ifndef ASSERT_OFF
`define APR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apr assertion failed");
`define APR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apr assertion failed");
`else
`define APR_ASSERT_IMPLY(lbl, ante, cons)
`define APR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/apr_pkg.sv
// Types, constants and command/status structs of the aging page replacement block.
package apr_pkg;
    localparam int MAX_PROCESSES  = 8;
    localparam int MAX_PAGES      = 64;
    localparam int MAX_FRAMES     = 64;
    localparam int AGE_BITS       = 8;
    localparam int MAX_PAGE_BYTES = 4096;
    localparam int ENTRIES        = MAX_PROCESSES * MAX_PAGES;

    localparam logic [1:0] CFG_PAGE_BYTES = 2'd0;
    localparam logic [1:0] CFG_PAGES      = 2'd1;
    localparam logic [1:0] CFG_FRAMES     = 2'd2;
    localparam logic [1:0] CFG_PROCESSES  = 2'd3;

    typedef struct packed {
        logic                present;
        logic                refd;
        logic                dirty;
        logic [5:0]          frame;
        logic [AGE_BITS-1:0] counter;
    } t_entry;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_DIV   = 12'b0000_0000_0100,
        ST_CHK   = 12'b0000_0000_1000,
        ST_CUR   = 12'b0000_0001_0000,
        ST_SRCH  = 12'b0000_0010_0000,
        ST_SDRN  = 12'b0000_0100_0000,
        ST_EVCT  = 12'b0000_1000_0000,
        ST_LOAD  = 12'b0001_0000_0000,
        ST_AGE   = 12'b0010_0000_0000,
        ST_ADRN  = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic div_step;
        logic chk;
        logic cap_cur;
        logic scan_init;
        logic scan_next;
        logic age_mode;
        logic evict;
        logic load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic bad;
        logic cur_present;
        logic room;
        logic scan_end;
        logic odd;
    } t_stat;
endpackage

// File: design/apr_ctrl.sv
// Controller state machine sequencing divide, lookup, victim search, load and aging.
`include "aging_page_replacement_assert.svh"
module apr_ctrl import apr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  s_axis_tvalid,
    output logic  s_axis_tready,
    output logic  m_axis_tvalid,
    input  logic  m_axis_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_oval, n_oval;
    logic   out_free;

    assign out_free      = !r_oval || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_oval;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = i_stat.bad ? ST_DONE : ST_CUR;
            end
            ST_CUR: begin
                o_cmd.cap_cur = 1'b1;
                if (i_stat.cur_present || i_stat.room) begin
                    n_state = ST_LOAD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                o_cmd.scan_next = 1'b1;
                if (i_stat.scan_end) n_state = ST_SDRN;
            end
            ST_SDRN: n_state = ST_EVCT;
            ST_EVCT: begin
                o_cmd.evict = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_stat.odd) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_AGE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_AGE: begin
                o_cmd.scan_next = 1'b1;
                o_cmd.age_mode  = 1'b1;
                if (i_stat.scan_end) n_state = ST_ADRN;
            end
            ST_ADRN: begin
                o_cmd.age_mode = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_oval = r_oval;
        if (m_axis_tready) n_oval = 1'b0;
        if (o_cmd.out_load) n_oval = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    `APR_ASSERT_NEXT(a_accept_div, s_axis_tvalid && s_axis_tready, r_state == ST_DIV)
    `APR_ASSERT_NEXT(a_done_out, (r_state == ST_DONE) && out_free, m_axis_tvalid)
endmodule

// File: design/apr_dp.sv
// Datapath: configuration, divider, entry memory, victim search, aging and result register.
`include "aging_page_replacement_assert.svh"
module apr_dp import apr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic [23:0] i_in_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [39:0] o_out_data
);
    logic [12:0] r_page_bytes;
    logic [6:0]  r_pages, r_frames;
    logic [3:0]  r_procs;
    logic [12:0] pb;
    logic [6:0]  np, nf;
    logic [3:0]  nproc;

    logic [2:0]  r_pid;
    logic        r_wr;
    logic [17:0] r_dq;
    logic [12:0] r_rem, div_t;
    logic [4:0]  r_dcnt;
    logic        div_ge;

    t_entry      mem [ENTRIES];
    t_entry      r_rdata, r_cur, wd, aged;
    logic [8:0]  ra, wa, r_clr, r_paddr, r_bi, r_vidx;
    logic        we;

    logic [2:0]  r_sp;
    logic [5:0]  r_sg;
    logic        r_pend, r_found, r_bdirty;
    logic [AGE_BITS-1:0] r_best;
    logic [5:0]  r_bframe, r_nframe;
    logic [6:0]  r_floaded;
    logic        r_odd, r_bad, r_fault, r_evicted, r_wb;
    logic [19:0] phys;

    assign pb    = (r_page_bytes == 13'd0) ? 13'd1 :
                   (r_page_bytes > 13'(MAX_PAGE_BYTES)) ? 13'(MAX_PAGE_BYTES) : r_page_bytes;
    assign np    = (r_pages == 7'd0) ? 7'd1 :
                   (r_pages > 7'(MAX_PAGES)) ? 7'(MAX_PAGES) : r_pages;
    assign nf    = (r_frames == 7'd0) ? 7'd1 :
                   (r_frames > 7'(MAX_FRAMES)) ? 7'(MAX_FRAMES) : r_frames;
    assign nproc = (r_procs == 4'd0) ? 4'd1 :
                   (r_procs > 4'(MAX_PROCESSES)) ? 4'(MAX_PROCESSES) : r_procs;

    assign div_t  = {r_rem[11:0], r_dq[17]};
    assign div_ge = (div_t >= pb);

    assign o_stat.clr_last    = &r_clr;
    assign o_stat.div_last    = (r_dcnt == 5'd17);
    assign o_stat.bad         = ({1'b0, r_pid} >= nproc) || (r_dq >= {11'd0, np});
    assign o_stat.cur_present = r_rdata.present;
    assign o_stat.room        = (r_floaded < nf);
    assign o_stat.scan_end    = ({1'b0, r_sp} == nproc - 4'd1) && ({1'b0, r_sg} == np - 7'd1);
    assign o_stat.odd         = r_odd;

    assign ra = i_cmd.chk ? {r_pid, r_dq[5:0]} : {r_sp, r_sg};

    always_comb begin
        aged         = r_rdata;
        aged.refd    = 1'b0;
        aged.counter = {r_rdata.refd, r_rdata.counter[AGE_BITS-1:1]};
    end

    always_comb begin
        we = 1'b0;
        wa = r_clr;
        wd = '0;
        if (i_cmd.clr_step) begin
            we = 1'b1;
        end else if (i_cmd.evict) begin
            we = r_found;
            wa = r_bi;
        end else if (i_cmd.load) begin
            we = 1'b1;
            wa = {r_pid, r_dq[5:0]};
            wd = '{present: 1'b1, refd: 1'b1, dirty: r_cur.dirty | r_wr,
                   frame: r_nframe, counter: r_cur.counter};
        end else if (r_pend && i_cmd.age_mode) begin
            we = 1'b1;
            wa = r_paddr;
            wd = aged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rdata <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= 13'd256;
            r_pages      <= 7'd64;
            r_frames     <= 7'd16;
            r_procs      <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAGE_BYTES: r_page_bytes <= i_cfg_data;
                CFG_PAGES:      r_pages      <= i_cfg_data[6:0];
                CFG_FRAMES:     r_frames     <= i_cfg_data[6:0];
                CFG_PROCESSES:  r_procs      <= i_cfg_data[3:0];
                default:        r_procs      <= r_procs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_floaded <= '0;
            r_odd     <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 9'd1;
            if (i_cmd.cap_cur && !r_rdata.present && o_stat.room) r_floaded <= r_floaded + 7'd1;
            if (i_cmd.load) r_odd <= !r_odd;
            r_pend <= i_cmd.scan_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= {r_sp, r_sg};
        if (i_cmd.load_in) begin
            r_pid     <= i_in_data[2:0];
            r_wr      <= i_in_data[3];
            r_dq      <= i_in_data[21:4];
            r_rem     <= '0;
            r_dcnt    <= '0;
            r_fault   <= 1'b0;
            r_evicted <= 1'b0;
            r_wb      <= 1'b0;
            r_vidx    <= '0;
            r_nframe  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq   <= {r_dq[16:0], div_ge};
            r_rem  <= div_ge ? div_t - pb : div_t;
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (i_cmd.chk) r_bad <= o_stat.bad;
        if (i_cmd.cap_cur) begin
            r_cur   <= r_rdata;
            r_fault <= !r_rdata.present;
            if (r_rdata.present) r_nframe <= r_rdata.frame;
            else if (o_stat.room) r_nframe <= r_floaded[5:0];
        end
        if (i_cmd.scan_init) begin
            r_sp    <= '0;
            r_sg    <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_next) begin
            if ({1'b0, r_sg} == np - 7'd1) begin
                r_sg <= '0;
                r_sp <= r_sp + 3'd1;
            end else begin
                r_sg <= r_sg + 6'd1;
            end
        end
        if (r_pend && !i_cmd.age_mode && r_rdata.present &&
            (!r_found || r_rdata.counter < r_best)) begin
            r_found  <= 1'b1;
            r_best   <= r_rdata.counter;
            r_bi     <= r_paddr;
            r_bframe <= r_rdata.frame;
            r_bdirty <= r_rdata.dirty;
        end
        if (i_cmd.evict) begin
            r_evicted <= r_found;
            r_wb      <= r_found & r_bdirty;
            r_vidx    <= r_found ? r_bi : 9'd0;
            r_nframe  <= r_found ? r_bframe : 6'd0;
        end
    end

    assign phys = ({14'd0, r_nframe} * {7'd0, pb}) + {7'd0, r_rem};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_bad) begin
                o_out_data <= {3'd0, 1'b1, 36'd0};
            end else begin
                o_out_data <= {3'd0, 1'b0, r_wb, r_vidx[5:0], r_vidx[8:6], r_evicted,
                               phys[17:0], r_nframe, r_fault};
            end
        end
    end

    `APR_ASSERT_IMPLY(a_frames_bound, 1'b1, r_floaded <= 7'(MAX_FRAMES))
endmodule

// File: design/aging_page_replacement.sv
// Top level of the aging page replacement unit.
// Input transactions on s_axis carry one memory access: tdata holds process_id,
// is_write and vaddr. Each access yields one result transaction on m_axis with the
// translation, fault, eviction and writeback flags, or bad_access alone when the
// process or page lies outside the configured range.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index and data.
// After reset the entry table is cleared entry by entry, during which s_axis_tready
// stays low; configuration writes are taken at any time.
// Each access runs the 18-step divider and a table lookup; a miss with no free frame
// adds a victim search that walks the whole table, and every second loaded access
// adds an aging sweep over the table. The entry memory has separate read and write
// addresses, and each walk reads the table entry by entry.
// The result sits in an output register; the next access is accepted while it waits,
// and the unit holds in its final step only if a second result is ready before the
// receiver has taken the first.
module aging_page_replacement import apr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // process_id[2:0], is_write[3], vaddr[21:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // fault[0], frame[6:1], phys_addr[24:7],
                                        // evicted[25], victim_process[28:26],
                                        // victim_page[34:29], writeback[35],
                                        // bad_access[36]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    apr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    apr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (m_axis_tdata)
    );
endmodule
